/* hdl/svac_pkg.sv */
package svac_pkg;

    // Sizing of the stores
    localparam int MAX_LAGS      = 64;
    localparam int MAX_PARTICLES = 1024;
    localparam int VEL_WIDTH     = 16;

    localparam int LAG_W     = $clog2(MAX_LAGS);
    localparam int NL_W      = $clog2(MAX_LAGS + 1);
    localparam int PART_W    = $clog2(MAX_PARTICLES);
    localparam int CNT_W     = $clog2(MAX_PARTICLES + 1);
    localparam int RING_AW   = LAG_W + PART_W;
    localparam int RING_DEPTH = MAX_LAGS * MAX_PARTICLES;
    localparam int SUM_AW    = 2 + LAG_W;
    localparam int SUM_DEPTH = 3 * MAX_LAGS;
    localparam int PROD_W    = 2 * VEL_WIDTH;
    localparam int DOT_W     = PROD_W + 2;
    localparam int ACC_W     = 64;

    // Fixed field widths of the stream payloads
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 168;
    localparam int CFG_DATA_W = 16;

    // Register reset values (thresholds 7.0 and 9.0 in Q8.8)
    localparam logic [6:0]  LAGS_RST     = 7'(MAX_LAGS);
    localparam logic [15:0] CADENCE_RST  = 16'd1;
    localparam logic [15:0] THR_LOW_RST  = 16'(7 * 256);
    localparam logic [15:0] THR_HIGH_RST = 16'(9 * 256);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LAGS     = 2'd0,
        REG_CADENCE  = 2'd1,
        REG_THR_LOW  = 2'd2,
        REG_THR_HIGH = 2'd3
    } reg_idx_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

endpackage

/* hdl/species_velocity_autocorrelation_unit.sv */
// Per-species velocity autocorrelation. Command 0 stores a velocity sample in the
// ring of recent configurations and adds its dot product with the same particle's
// velocity at each active lag into a saturating 64-bit sum per species and lag.
// A sample is accepted, then the lag loop reads one stored velocity and one sum per
// cycle through the ring and sum memory read ports, then the multiply/accumulate
// pipeline drains; s_tready stays low through the loop and the drain. Command 1 reads
// one sum and returns it with its species count, lag time and the sum divided by the
// count, computed by a bit-serial divider (one quotient bit per cycle) that is skipped
// for an empty species; no new command is accepted until the result has entered the
// output register, and that waits until the register is free.
// Command 2 clears sums and counters; the velocity ring keeps its data.
// The sum memory starts cleared after reset, with no clearing pass.
module species_velocity_autocorrelation_unit
    import svac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // cfg port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vel_x[15:0], vel_y[31:16], vel_z[47:32], particle_charge[63:48],
    // read_lag[69:64], read_species[71:70]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // average[63:0], raw_sum[127:64], species_count[138:128], lag_time[160:139],
    // status[162:161], zero pad above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAG,
        S_DRAIN,
        S_RD_WAIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [6:0]  lags_reg;
    logic [15:0] cadence_reg;
    logic [15:0] thr_low_reg;
    logic [15:0] thr_high_reg;

    // counters
    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] pc_reg;
    logic [LAG_W-1:0] slot_reg;
    logic [NL_W-1:0]  seen_reg;
    logic             ovf_reg;

    // current sample
    logic signed [VEL_WIDTH-1:0] cur_vx_reg, cur_vy_reg, cur_vz_reg;
    logic [1:0]        cur_sp_reg;
    logic [LAG_W-1:0]  cur_slot_reg;
    logic [PART_W-1:0] cur_pc_reg;
    logic [NL_W-1:0]   nl_reg;
    logic [NL_W-1:0]   lag_reg;

    // memories
    logic [3*VEL_WIDTH-1:0] ring_mem [RING_DEPTH];
    logic [3*VEL_WIDTH-1:0] ring_q_reg;
    logic [ACC_W-1:0]       sums_mem [SUM_DEPTH];
    logic [ACC_W-1:0]       sums_q_reg;
    logic                   sum_vld_reg [SUM_DEPTH];
    logic                   ring_we;
    logic [RING_AW-1:0]     ring_waddr;
    logic [RING_AW-1:0]     ring_raddr;
    logic [SUM_AW-1:0]      sums_raddr;

    // accumulate pipeline
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [SUM_AW-1:0] p1_addr_reg, p2_addr_reg, p3_addr_reg;
    logic              p1_svld_reg;
    logic signed [ACC_W-1:0]  p2_sum_reg, p3_sum_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [DOT_W-1:0]  dot_reg;

    // read / divide
    logic              rd_svld_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic [21:0]       rd_ltime_reg;
    logic [1:0]        rd_stat_reg;
    logic [ACC_W-1:0]  rd_sum_reg;
    logic              div_neg_reg;
    logic [ACC_W-1:0]  div_quo_reg;
    logic [CNT_W:0]    div_rem_reg;
    logic [6:0]        div_cnt_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // input decode
    logic [1:0]                  in_cmd;
    logic signed [VEL_WIDTH-1:0] in_vx, in_vy, in_vz;
    logic [15:0]                 in_charge;
    logic [5:0]                  in_lag;
    logic [1:0]                  in_sp_rd;
    logic [1:0]                  in_sp;
    logic [1:0]                  rd_sp;
    logic [LAG_W-1:0]            rd_lidx;
    logic                        accept;
    logic [NL_W-1:0]             nl_cfg;
    logic [NL_W:0]               seen_p1;
    logic [NL_W-1:0]             nl_next;

    logic signed [VEL_WIDTH-1:0] w_x, w_y, w_z;
    logic signed [ACC_W:0]       sat_wide;
    logic [ACC_W-1:0]            sat_sum;
    logic [CNT_W:0]              rem_shift;
    logic                        div_ge;
    logic [ACC_W-1:0]            sum_rd;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_cmd    = s_tuser;
    assign in_vx     = s_tdata[VEL_WIDTH-1:0];
    assign in_vy     = s_tdata[16+VEL_WIDTH-1:16];
    assign in_vz     = s_tdata[32+VEL_WIDTH-1:32];
    assign in_charge = s_tdata[63:48];
    assign in_lag    = s_tdata[69:64];
    assign in_sp_rd  = s_tdata[71:70];

    // species of the incoming sample
    always_comb begin
        if (in_charge < thr_low_reg) begin
            in_sp = 2'd0;
        end else if (in_charge < thr_high_reg) begin
            in_sp = 2'd1;
        end else begin
            in_sp = 2'd2;
        end
    end

    assign rd_sp   = (in_sp_rd == 2'd3) ? 2'd2 : in_sp_rd;
    assign rd_lidx = (32'(in_lag) >= MAX_LAGS) ? LAG_W'(MAX_LAGS - 1) : LAG_W'(in_lag);

    // active lag count: clamp register, then limit to configurations seen
    always_comb begin
        if (lags_reg == 7'd0) begin
            nl_cfg = NL_W'(1);
        end else if (32'(lags_reg) > MAX_LAGS) begin
            nl_cfg = NL_W'(MAX_LAGS);
        end else begin
            nl_cfg = NL_W'(lags_reg);
        end
        seen_p1 = {1'b0, seen_reg} + 1'b1;
        nl_next = ((NL_W+1)'(nl_cfg) > seen_p1) ? NL_W'(seen_p1) : nl_cfg;
    end

    // memory addressing
    assign ring_we    = accept && (in_cmd == CMD_SAMPLE) && (32'(pc_reg) < MAX_PARTICLES);
    assign ring_waddr = {slot_reg, pc_reg[PART_W-1:0]};
    assign ring_raddr = {cur_slot_reg - lag_reg[LAG_W-1:0], cur_pc_reg};
    assign sums_raddr = (state_reg == S_LAG) ? {cur_sp_reg, lag_reg[LAG_W-1:0]}
                                             : {rd_sp, rd_lidx};

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= {in_vz, in_vy, in_vx};
        end
        ring_q_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p3_valid_reg) begin
            sums_mem[p3_addr_reg] <= sat_sum;
        end
        sums_q_reg <= sums_mem[sums_raddr];
    end

    // unpack stored velocity
    assign w_x = ring_q_reg[VEL_WIDTH-1:0];
    assign w_y = ring_q_reg[2*VEL_WIDTH-1:VEL_WIDTH];
    assign w_z = ring_q_reg[3*VEL_WIDTH-1:2*VEL_WIDTH];

    // saturating accumulate
    always_comb begin
        sat_wide = {p3_sum_reg[ACC_W-1], p3_sum_reg} + (ACC_W+1)'(dot_reg);
        if (sat_wide[ACC_W] != sat_wide[ACC_W-1]) begin
            sat_sum = sat_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_sum = sat_wide[ACC_W-1:0];
        end
    end

    // divider step
    assign rem_shift = {div_rem_reg[CNT_W-1:0], div_quo_reg[ACC_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, rd_cnt_reg});
    assign sum_rd    = rd_svld_reg ? sums_q_reg : '0;

    // control, counters and pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            lags_reg     <= LAGS_RST;
            cadence_reg  <= CADENCE_RST;
            thr_low_reg  <= THR_LOW_RST;
            thr_high_reg <= THR_HIGH_RST;
            for (int i = 0; i < 3; i++) begin
                cnt_reg[i] <= '0;
            end
            pc_reg       <= '0;
            slot_reg     <= '0;
            seen_reg     <= '0;
            ovf_reg      <= 1'b0;
            for (int i = 0; i < SUM_DEPTH; i++) begin
                sum_vld_reg[i] <= 1'b0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                unique case (reg_idx_t'(cfg_addr))
                    REG_LAGS:     lags_reg     <= cfg_wr_data[6:0];
                    REG_CADENCE:  cadence_reg  <= cfg_wr_data;
                    REG_THR_LOW:  thr_low_reg  <= cfg_wr_data;
                    REG_THR_HIGH: thr_high_reg <= cfg_wr_data;
                    default: ;
                endcase
            end

            // drop delivered result
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            // advance accumulate pipeline
            p1_valid_reg <= (state_reg == S_LAG);
            p1_addr_reg  <= sums_raddr;
            p1_svld_reg  <= sum_vld_reg[sums_raddr];
            p2_valid_reg <= p1_valid_reg;
            p2_addr_reg  <= p1_addr_reg;
            p2_sum_reg   <= p1_svld_reg ? sums_q_reg : '0;
            px_reg       <= cur_vx_reg * w_x;
            py_reg       <= cur_vy_reg * w_y;
            pz_reg       <= cur_vz_reg * w_z;
            p3_valid_reg <= p2_valid_reg;
            p3_addr_reg  <= p2_addr_reg;
            p3_sum_reg   <= p2_sum_reg;
            dot_reg      <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
            if (p3_valid_reg) begin
                sum_vld_reg[p3_addr_reg] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (in_cmd)
                            CMD_SAMPLE: begin
                                if (32'(pc_reg) >= MAX_PARTICLES) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    cur_vx_reg   <= in_vx;
                                    cur_vy_reg   <= in_vy;
                                    cur_vz_reg   <= in_vz;
                                    cur_sp_reg   <= in_sp;
                                    cur_slot_reg <= slot_reg;
                                    cur_pc_reg   <= pc_reg[PART_W-1:0];
                                    nl_reg       <= nl_next;
                                    lag_reg      <= '0;
                                    if (seen_reg == '0) begin
                                        cnt_reg[in_sp] <= cnt_reg[in_sp] + 1'b1;
                                    end
                                    if (!s_tlast) begin
                                        pc_reg <= pc_reg + 1'b1;
                                    end
                                    state_reg <= S_LAG;
                                end
                                // close the configuration
                                if (s_tlast) begin
                                    pc_reg   <= '0;
                                    slot_reg <= slot_reg + 1'b1;
                                    if (32'(seen_reg) < MAX_LAGS) begin
                                        seen_reg <= seen_reg + 1'b1;
                                    end
                                end
                            end
                            CMD_READ: begin
                                rd_svld_reg  <= sum_vld_reg[{rd_sp, rd_lidx}];
                                rd_cnt_reg   <= cnt_reg[rd_sp];
                                rd_ltime_reg <= 22'(in_lag) * 22'(cadence_reg);
                                if (cnt_reg[rd_sp] == '0) begin
                                    rd_stat_reg <= STAT_EMPTY;
                                end else if (ovf_reg) begin
                                    rd_stat_reg <= STAT_OVERFLOW;
                                end else begin
                                    rd_stat_reg <= STAT_OK;
                                end
                                state_reg <= S_RD_WAIT;
                            end
                            CMD_CLEAR: begin
                                for (int i = 0; i < 3; i++) begin
                                    cnt_reg[i] <= '0;
                                end
                                for (int i = 0; i < SUM_DEPTH; i++) begin
                                    sum_vld_reg[i] <= 1'b0;
                                end
                                pc_reg   <= '0;
                                slot_reg <= '0;
                                seen_reg <= '0;
                                ovf_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end

                // issue one lag per cycle
                S_LAG: begin
                    lag_reg <= lag_reg + 1'b1;
                    if (lag_reg == nl_reg - 1'b1) begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg) begin
                        state_reg <= S_IDLE;
                    end
                end

                // sum arrives; set up division on its magnitude
                S_RD_WAIT: begin
                    rd_sum_reg  <= sum_rd;
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    if (rd_cnt_reg == '0) begin
                        div_quo_reg <= '0;
                        div_neg_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end else begin
                        div_neg_reg <= sum_rd[ACC_W-1];
                        div_quo_reg <= sum_rd[ACC_W-1] ? (~sum_rd + 1'b1) : sum_rd;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV: begin
                    div_rem_reg <= div_ge ? (rem_shift - {1'b0, rd_cnt_reg}) : rem_shift;
                    div_quo_reg <= {div_quo_reg[ACC_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 7'(ACC_W - 1)) begin
                        state_reg <= S_OUT;
                    end
                end

                // hold until the output register is free
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'd0, rd_stat_reg, rd_ltime_reg, rd_cnt_reg,
                                        rd_sum_reg,
                                        div_neg_reg ? (~div_quo_reg + 1'b1) : div_quo_reg};
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* sim/species_velocity_autocorrelation_checker.sv */
// Watches both channels of the autocorrelation unit, predicts each read result
// and compares it field by field with what the block returns.
module species_velocity_autocorrelation_checker
    import svac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    readings_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint      average;
        longint      raw_sum;
        logic [10:0] count;
        logic [21:0] lag_time;
        logic [1:0]  status;
    } vacf_reading_t;

    // Register copies
    logic [6:0]  lags_reg;
    logic [15:0] cadence_reg;
    logic [15:0] thr_low_reg;
    logic [15:0] thr_high_reg;

    // Predicted block state
    shortint ring_x [RING_DEPTH];
    shortint ring_y [RING_DEPTH];
    shortint ring_z [RING_DEPTH];
    longint  lag_sum [3][MAX_LAGS];
    int      species_cnt [3];
    int      part_idx;
    int      slot_idx;
    int      configs_done;
    bit      overflowed;

    vacf_reading_t readings_due [$];

    initial begin
        fail_count       = 0;
        readings_pending = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        return s;
    endfunction

    task automatic clear_sums();
        for (int s = 0; s < 3; s++) begin
            species_cnt[s] = 0;
            for (int l = 0; l < MAX_LAGS; l++)
                lag_sum[s][l] = 0;
        end
        part_idx     = 0;
        slot_idx     = 0;
        configs_done = 0;
        overflowed   = 0;
    endtask

    // Store one sample and add its dot products over the active lags
    task automatic accumulate_sample(input logic [IN_DATA_W-1:0] d, input logic last);
        logic [15:0] charge;
        int          sp;
        int          nl;
        int          here;
        int          there;
        longint      dot;
        charge = d[63:48];
        sp = (charge < thr_low_reg) ? 0 : ((charge < thr_high_reg) ? 1 : 2);
        if (part_idx >= MAX_PARTICLES) begin
            overflowed = 1;
        end else begin
            here = slot_idx * MAX_PARTICLES + part_idx;
            ring_x[here] = d[15:0];
            ring_y[here] = d[31:16];
            ring_z[here] = d[47:32];
            nl = (lags_reg == 0) ? 1 : int'(lags_reg);
            if (nl > MAX_LAGS) nl = MAX_LAGS;
            if (nl > configs_done + 1) nl = configs_done + 1;
            for (int l = 0; l < nl; l++) begin
                there = ((slot_idx + MAX_LAGS - l) % MAX_LAGS) * MAX_PARTICLES + part_idx;
                dot = longint'(ring_x[here]) * longint'(ring_x[there])
                    + longint'(ring_y[here]) * longint'(ring_y[there])
                    + longint'(ring_z[here]) * longint'(ring_z[there]);
                lag_sum[sp][l] = sat_add(lag_sum[sp][l], dot);
            end
            if (configs_done == 0) species_cnt[sp]++;
            part_idx++;
        end
        if (last) begin
            part_idx = 0;
            slot_idx = (slot_idx + 1) % MAX_LAGS;
            if (configs_done < MAX_LAGS) configs_done++;
        end
    endtask

    task automatic predict_reading(input logic [IN_DATA_W-1:0] d);
        vacf_reading_t r;
        int            lag;
        int            sp;
        lag = int'(d[69:64]);
        sp  = int'(d[71:70]);
        if (sp > 2) sp = 2;
        r.raw_sum  = lag_sum[sp][(lag < MAX_LAGS) ? lag : MAX_LAGS - 1];
        r.count    = 11'(species_cnt[sp]);
        r.lag_time = 22'(lag * int'(cadence_reg));
        if (species_cnt[sp] == 0) begin
            r.average = 0;
            r.status  = STAT_EMPTY;
        end else begin
            r.average = r.raw_sum / longint'(species_cnt[sp]);
            r.status  = overflowed ? STAT_OVERFLOW : STAT_OK;
        end
        readings_due.push_back(r);
    endtask

    task automatic check_reading(input logic [OUT_DATA_W-1:0] d);
        vacf_reading_t r;
        if (readings_due.size() == 0) begin
            report_mismatch("unexpected result", longint'(d[63:0]), 0);
            return;
        end
        r = readings_due.pop_front();
        if (d[63:0] !== r.average)     report_mismatch("average", d[63:0], r.average);
        if (d[127:64] !== r.raw_sum)   report_mismatch("raw_sum", d[127:64], r.raw_sum);
        if (d[138:128] !== r.count)    report_mismatch("species_count", d[138:128], r.count);
        if (d[160:139] !== r.lag_time) report_mismatch("lag_time", d[160:139], r.lag_time);
        if (d[162:161] !== r.status)   report_mismatch("status", d[162:161], r.status);
    endtask

    // Follow every transaction seen on the ports
    always @(posedge aclk) begin
        if (!aresetn) begin
            lags_reg     = LAGS_RST;
            cadence_reg  = CADENCE_RST;
            thr_low_reg  = THR_LOW_RST;
            thr_high_reg = THR_HIGH_RST;
            clear_sums();
            readings_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_addr))
                    REG_LAGS:     lags_reg     = cfg_wr_data[6:0];
                    REG_CADENCE:  cadence_reg  = cfg_wr_data;
                    REG_THR_LOW:  thr_low_reg  = cfg_wr_data;
                    REG_THR_HIGH: thr_high_reg = cfg_wr_data;
                endcase
            end
            if (m_tvalid && m_tready) check_reading(m_tdata);
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_SAMPLE: accumulate_sample(s_tdata, s_tlast);
                    CMD_READ:   predict_reading(s_tdata);
                    CMD_CLEAR:  clear_sums();
                    default:    ;
                endcase
            end
        end
        readings_pending = readings_due.size();
    end

endmodule

/* sim/species_velocity_autocorrelation_unit_test.sv */
module species_velocity_autocorrelation_unit_test;
    import svac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         SETTLE      = 90;
    localparam int         HOLD_CYCLES = 3000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    readings_pending;

    // Stimulus-side view of the ring, to keep reads on written entries
    int lags_now;
    int ring_pos;
    int configs_seen;
    int part_pos;
    int slot_fill [MAX_LAGS];
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    int items_sent;

    species_velocity_autocorrelation_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    species_velocity_autocorrelation_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .readings_pending(readings_pending)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random backpressure plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_charge();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(1700, 2400));
            1:       return 16'($urandom_range(0, 4096));
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] d,
                             input logic last);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_sample(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vz, input logic [15:0] charge,
                               input logic last);
        logic [7:0] sel;
        sel = 8'($urandom());
        send_item(CMD_SAMPLE, {sel, charge, vz, vy, vx}, last);
        if (part_pos < MAX_PARTICLES) begin
            if (slot_fill[ring_pos] < part_pos + 1) slot_fill[ring_pos] = part_pos + 1;
            part_pos++;
        end
        if (last) begin
            part_pos = 0;
            ring_pos = (ring_pos + 1) % MAX_LAGS;
            if (configs_seen < MAX_LAGS) configs_seen++;
        end
    endtask

    task automatic send_read(input int lag, input int sp);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        send_item(CMD_READ, {2'(sp), 6'(lag), junk}, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, IN_DATA_W'({$urandom(), $urandom(), $urandom()}),
                  1'($urandom_range(0, 1)));
        part_pos     = 0;
        ring_pos     = 0;
        configs_seen = 0;
    endtask

    // Largest configuration whose lag reads all land on written entries
    function automatic int allowed_particles();
        int nl;
        int lim;
        nl = (lags_now == 0) ? 1 : lags_now;
        if (nl > MAX_LAGS) nl = MAX_LAGS;
        if (nl > configs_seen + 1) nl = configs_seen + 1;
        lim = MAX_PARTICLES;
        for (int l = 1; l < nl; l++)
            if (slot_fill[(ring_pos + MAX_LAGS - l) % MAX_LAGS] < lim)
                lim = slot_fill[(ring_pos + MAX_LAGS - l) % MAX_LAGS];
        return lim;
    endfunction

    // Wait until every result is back and the block has settled
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (readings_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_regs(input int lags, input logic [15:0] cad,
                              input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] lag_word;
        lag_word = {9'($urandom_range(0, 511)), 7'(lags)};
        cfg_wr_en <= 1;
        cfg_addr <= REG_LAGS;     cfg_wr_data <= lag_word; @(posedge aclk);
        cfg_addr <= REG_CADENCE;  cfg_wr_data <= cad;      @(posedge aclk);
        cfg_addr <= REG_THR_LOW;  cfg_wr_data <= lo;       @(posedge aclk);
        cfg_addr <= REG_THR_HIGH; cfg_wr_data <= hi;       @(posedge aclk);
        cfg_wr_en <= 0;
        lags_now = lags;
    endtask

    // One configuration of random samples with reads and unused commands mixed in
    task automatic run_config(input int want);
        int n;
        n = allowed_particles();
        if (want < n) n = want;
        for (int p = 0; p < n; p++) begin
            if ($urandom_range(0, 99) < 15)
                send_read($urandom_range(0, 63), $urandom_range(0, 3));
            if ($urandom_range(0, 99) < 3)
                send_item(CMD_UNUSED, IN_DATA_W'({$urandom(), $urandom(), $urandom()}),
                          1'b1);
            send_sample(pick_velocity(), pick_velocity(), pick_velocity(), pick_charge(),
                        p == n - 1);
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        int roll;
        start = items_sent;
        while (items_sent - start < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                run_config($urandom_range(1, 6));
            end else if (roll < 92) begin
                repeat ($urandom_range(1, 6))
                    send_read($urandom_range(0, 63), $urandom_range(0, 3));
            end else if (roll < 96) begin
                send_clear();
            end else begin
                send_item(CMD_UNUSED, IN_DATA_W'({$urandom(), $urandom(), $urandom()}),
                          1'b0);
            end
        end
    endtask

    task automatic random_regs();
        int lags;
        case ($urandom_range(0, 4))
            0:       lags = 0;
            1:       lags = 64;
            2:       lags = 127;
            default: lags = $urandom_range(1, 64);
        endcase
        write_regs(lags, 16'($urandom()), pick_charge(), pick_charge());
    endtask

    initial begin
        aresetn      = 0;
        cfg_wr_en    = 0;
        cfg_addr     = REG_LAGS;
        cfg_wr_data  = 0;
        s_tvalid     = 0;
        s_tdata      = 0;
        s_tuser      = CMD_SAMPLE;
        s_tlast      = 0;
        hold_request = 0;
        tx_idle_pct  = 7;
        rx_idle_pct  = 78;
        lags_now     = 64;
        ring_pos     = 0;
        configs_seen = 0;
        part_pos     = 0;
        items_sent   = 0;
        foreach (slot_fill[i]) slot_fill[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings, extreme velocities, charges on the thresholds
        send_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'd1791, 0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'd1792, 0);
        send_sample(16'hffff, 16'h0001, 16'h8000, 16'd2303, 0);
        send_sample(16'h8000, 16'h7fff, 16'hffff, 16'd2304, 0);
        send_sample(16'h0000, 16'h0000, 16'h7fff, 16'hffff, 1);
        for (int s = 0; s < 4; s++) send_read(0, s);
        send_item(CMD_UNUSED, {72{1'b1}}, 1'b1);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000, 0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'd1792, 1);
        send_read(1, 0);
        send_read(1, 1);
        send_read(5, 2);
        send_read(63, 3);
        send_clear();
        send_read(0, 0);
        drain();

        // Overflow: one configuration past the particle limit, wide cadence
        write_regs(1, 16'hffff, 16'h0000, 16'hffff);
        send_clear();
        for (int p = 0; p < MAX_PARTICLES + 2; p++)
            send_sample(pick_velocity(), pick_velocity(), pick_velocity(), pick_charge(),
                        p == MAX_PARTICLES + 1);
        send_read(0, 0);
        send_read(0, 1);
        send_read(63, 2);
        send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'h0100, 1);
        send_read(1, 1);
        send_read(0, 1);
        send_clear();
        drain();

        // Random phases with changing registers and idling patterns
        write_regs(64, 16'h0000, 16'hffff, 16'h0000);
        random_phase(160);
        drain();
        tx_idle_pct = 78;
        rx_idle_pct = 7;
        random_regs();
        random_phase(85);
        drain();
        random_regs();
        random_phase(85);
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_regs();
        hold_request = 1;
        random_phase(170);
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
